// File: rtl/hbs_pkg.sv
// Shared constants, types and codes for the heightmap bilinear sampler.
// No dependencies; every other file in rtl/ except hbs_ram imports this package.
package hbs_pkg;

  localparam int MAX_DIM     = 512;
  localparam int FRAC_BITS   = 8;

  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int COL_W       = 9;
  localparam int BYTE_W      = 8;
  localparam int COORD_W     = 18;
  localparam int OUT_W       = 24;

  localparam int FRAC_W      = FRAC_BITS;
  localparam int ONE_W       = FRAC_BITS + 1;
  localparam int HX_W        = BYTE_W + FRAC_BITS;
  localparam int RES_W       = BYTE_W + 2 * FRAC_BITS;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_H00 = 2'd0,
    PH_H10 = 2'd1,
    PH_H01 = 2'd2,
    PH_H11 = 2'd3
  } phase_e;

  // Sideband that travels with each RAM read, aligned with the read data.
  typedef struct packed {
    logic              valid;
    phase_e            phase;
    logic [FRAC_W-1:0] tx;
    logic [FRAC_W-1:0] tz;
    logic              zero;
  } rd_tag_t;

endpackage

// File: rtl/hbs_req_if.sv
// Request channel of the heightmap sampler: valid/ready plus write and
// query payload. Depends on hbs_pkg for field widths.
interface hbs_req_if;
  import hbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [COL_W-1:0]          load_col;
  logic [COL_W-1:0]          load_row;
  logic [BYTE_W-1:0]         load_value;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_z;

  modport source (
    output valid, req_type, load_col, load_row, load_value, query_x, query_z,
    input  ready
  );

  modport sink (
    input  valid, req_type, load_col, load_row, load_value, query_x, query_z,
    output ready
  );

endinterface

// File: rtl/hbs_rsp_if.sv
// Result channel of the heightmap sampler: valid/ready plus the height.
// Depends on hbs_pkg for the field width.
interface hbs_rsp_if;
  import hbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] height_value;

  modport source (
    output valid, height_value,
    input  ready
  );

  modport sink (
    input  valid, height_value,
    output ready
  );

endinterface

// File: rtl/hbs_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module hbs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hbs_issue.sv
// Request front end: takes requests, clamps query coordinates and drives the
// height RAM port, one access per cycle while a command is held. Depends on hbs_pkg and hbs_req_if.
module hbs_issue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  hbs_req_if.sink               req_i,
  input  logic                  can_query_i,
  input  logic [hbs_pkg::CFG_W-1:0] map_width_i,
  input  logic [hbs_pkg::CFG_W-1:0] map_height_i,
  output logic                  qry_acc_o,
  output logic                  mem_we_o,
  output logic [hbs_pkg::ADDR_W-1:0] mem_addr_o,
  output logic [hbs_pkg::BYTE_W-1:0] mem_wdata_o,
  output hbs_pkg::rd_tag_t      tag_o
);
  import hbs_pkg::*;

  localparam int DIMP1_W = DIM_W + 1;
  localparam int CX_W    = DIM_W + FRAC_BITS;
  localparam int CMP_W   = (COORD_W - 1 > DIMP1_W + FRAC_BITS) ? COORD_W - 1
                                                                : DIMP1_W + FRAC_BITS;

  typedef struct packed {
    logic              is_query;
    logic              wr_ok;
    logic [DIM_W-1:0]  wcol;
    logic [DIM_W-1:0]  wrow;
    logic [BYTE_W-1:0] wdata;
    logic [DIM_W-1:0]  x0;
    logic [DIM_W-1:0]  x1;
    logic [DIM_W-1:0]  z0;
    logic [DIM_W-1:0]  z1;
    logic [FRAC_W-1:0] tx;
    logic [FRAC_W-1:0] tz;
    logic              zero;
  } cmd_t;

  function automatic logic [CX_W-1:0] clamp_coord(
    input logic signed [COORD_W-1:0] v,
    input logic [DIMP1_W-1:0]        dim
  );
    logic [CMP_W-1:0] hi;
    logic [CMP_W-1:0] mag;
    hi  = CMP_W'(dim - 1'b1) << FRAC_BITS;
    mag = CMP_W'(v[COORD_W-2:0]);
    if (v[COORD_W-1]) begin
      return '0;
    end else if (mag > hi) begin
      return CX_W'(hi);
    end
    return CX_W'(mag);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(
    input logic [DIM_W-1:0] col,
    input logic [DIM_W-1:0] row
  );
    return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
  endfunction

  logic               cmd_valid_q, cmd_valid_d;
  cmd_t               cmd_q, cmd_d;
  phase_e             ph_q, ph_d;
  rd_tag_t            tag_q, tag_d;
  logic               issue_done, accept;
  logic [DIMP1_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0]   wm1, hm1;
  logic [CX_W-1:0]    cx, cz;

  always_comb begin
    w_eff = (int'(map_width_i)  > MAX_DIM) ? DIMP1_W'(MAX_DIM) : DIMP1_W'(map_width_i);
    h_eff = (int'(map_height_i) > MAX_DIM) ? DIMP1_W'(MAX_DIM) : DIMP1_W'(map_height_i);
    wm1   = DIM_W'(w_eff - 1'b1);
    hm1   = DIM_W'(h_eff - 1'b1);
    cx    = clamp_coord(req_i.query_x, w_eff);
    cz    = clamp_coord(req_i.query_z, h_eff);

    cmd_d          = cmd_q;
    cmd_d.is_query = req_i.req_type;
    cmd_d.wr_ok    = (int'(req_i.load_col) < MAX_DIM) && (int'(req_i.load_row) < MAX_DIM);
    cmd_d.wcol     = DIM_W'(req_i.load_col);
    cmd_d.wrow     = DIM_W'(req_i.load_row);
    cmd_d.wdata    = req_i.load_value;
    cmd_d.x0       = cx[CX_W-1:FRAC_BITS];
    cmd_d.z0       = cz[CX_W-1:FRAC_BITS];
    cmd_d.tx       = cx[FRAC_BITS-1:0];
    cmd_d.tz       = cz[FRAC_BITS-1:0];
    // Far neighbour stops at the last column/row.
    cmd_d.x1       = (cmd_d.x0 == wm1) ? cmd_d.x0 : cmd_d.x0 + 1'b1;
    cmd_d.z1       = (cmd_d.z0 == hm1) ? cmd_d.z0 : cmd_d.z0 + 1'b1;
    cmd_d.zero     = (w_eff < DIMP1_W'(2)) || (h_eff < DIMP1_W'(2));

    issue_done   = cmd_valid_q && (!cmd_q.is_query || ph_q == PH_H11);
    req_i.ready  = (!cmd_valid_q || issue_done) && can_query_i;
    accept       = req_i.valid && req_i.ready;
    qry_acc_o    = accept && req_i.req_type;

    cmd_valid_d = cmd_valid_q;
    if (accept) begin
      cmd_valid_d = 1'b1;
    end else if (issue_done) begin
      cmd_valid_d = 1'b0;
    end

    ph_d = ph_q;
    if (accept) begin
      ph_d = PH_H00;
    end else if (cmd_valid_q && cmd_q.is_query) begin
      ph_d = phase_e'(ph_q + 2'd1);
    end

    mem_we_o    = cmd_valid_q && !cmd_q.is_query && cmd_q.wr_ok;
    mem_wdata_o = cmd_q.wdata;
    if (!cmd_q.is_query) begin
      mem_addr_o = cell_addr(cmd_q.wcol, cmd_q.wrow);
    end else begin
      unique case (ph_q)
        PH_H00:  mem_addr_o = cell_addr(cmd_q.x0, cmd_q.z0);
        PH_H10:  mem_addr_o = cell_addr(cmd_q.x1, cmd_q.z0);
        PH_H01:  mem_addr_o = cell_addr(cmd_q.x0, cmd_q.z1);
        PH_H11:  mem_addr_o = cell_addr(cmd_q.x1, cmd_q.z1);
        default: mem_addr_o = cell_addr(cmd_q.x0, cmd_q.z0);
      endcase
    end

    tag_d.valid = cmd_valid_q && cmd_q.is_query;
    tag_d.phase = ph_q;
    tag_d.tx    = cmd_q.tx;
    tag_d.tz    = cmd_q.tz;
    tag_d.zero  = cmd_q.zero;
  end

  // Tag sideband follows the RAM read latency.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      ph_q        <= PH_H00;
      tag_q       <= '0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      ph_q        <= ph_d;
      tag_q       <= tag_d;
    end
  end

  // Command payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign tag_o = tag_q;

endmodule

// File: rtl/hbs_blend.sv
// Bilinear blend pipeline: gathers the four neighbour bytes from the RAM
// read stream and forms the exact weighted sum, or zero for a map under two cells wide or high. Depends on hbs_pkg.
module hbs_blend (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hbs_pkg::rd_tag_t         tag_i,
  input  logic [hbs_pkg::BYTE_W-1:0] rdata_i,
  output logic                     push_o,
  output logic [hbs_pkg::OUT_W-1:0] push_data_o
);
  import hbs_pkg::*;

  localparam int PX_W  = BYTE_W + ONE_W;
  localparam int PR_W  = HX_W + ONE_W;
  localparam int SAT_W = (RES_W > OUT_W) ? RES_W : OUT_W;
  localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

  logic [BYTE_W-1:0] h00_q, h01_q;
  logic [HX_W-1:0]   hx0_q, hx1_q, hx_d;
  logic [FRAC_W-1:0] tz_q;
  logic              zero_q, hx1_vld_q, hx1_vld_d;
  logic [OUT_W-1:0]  res_q, res_d;
  logic              res_vld_q;
  logic [ONE_W-1:0]  wtx, wtz;
  logic [PX_W-1:0]   px_near, px_far;
  logic [PR_W-1:0]   pr_near, pr_far;
  logic [SAT_W-1:0]  r_ext;

  always_comb begin
    // Horizontal blend of the held near byte with the byte just read.
    wtx     = ONE - ONE_W'(tag_i.tx);
    px_near = PX_W'(tag_i.phase == PH_H11 ? h01_q : h00_q) * PX_W'(wtx);
    px_far  = PX_W'(rdata_i) * PX_W'(tag_i.tx);
    hx_d    = HX_W'(px_near + px_far);
    hx1_vld_d = tag_i.valid && (tag_i.phase == PH_H11);

    wtz     = ONE - ONE_W'(tz_q);
    pr_near = PR_W'(hx0_q) * PR_W'(wtz);
    pr_far  = PR_W'(hx1_q) * PR_W'(tz_q);
    r_ext   = SAT_W'(RES_W'(pr_near + pr_far));
    if (zero_q) begin
      res_d = '0;
    end else if (r_ext > SAT_W'(OUT_MAX)) begin
      res_d = OUT_MAX;
    end else begin
      res_d = OUT_W'(r_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.valid) begin
      case (tag_i.phase)
        PH_H00: h00_q <= rdata_i;
        PH_H10: hx0_q <= hx_d;
        PH_H01: h01_q <= rdata_i;
        PH_H11: begin
          hx1_q  <= hx_d;
          tz_q   <= tag_i.tz;
          zero_q <= tag_i.zero;
        end
        default: ;
      endcase
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hx1_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      hx1_vld_q <= hx1_vld_d;
      res_vld_q <= hx1_vld_q;
    end
  end

  assign push_o      = res_vld_q;
  assign push_data_o = res_q;

endmodule

// File: rtl/heightmap_bilinear_sampler_top.sv
// Top level of the heightmap bilinear sampler: configuration registers,
// height RAM, issue front end, blend pipeline and result queue.
// Depends on hbs_pkg, hbs_req_if, hbs_rsp_if, hbs_ram, hbs_issue, hbs_blend.
//
// A write request holds the single RAM port for one access; a query holds it
// for four reads, one per neighbour, so writes go one per cycle while credit is
// free. A query result passes the RAM read and tag registers, the horizontal blend
// register and the result register, then waits in the result queue. Up to four
// queries may be outstanding; the result queue absorbs them, so requests keep
// flowing while a result waits, until four queries are outstanding. The
// height RAM is not cleared: read only entries that were written.
module heightmap_bilinear_sampler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hbs_pkg::CFG_W-1:0]     cfg_data_i,
  hbs_req_if.sink                       req_i,
  hbs_rsp_if.source                     rsp_o
);
  import hbs_pkg::*;

  logic [CFG_W-1:0]      map_width_q, map_height_q;
  logic                  can_query, qry_acc;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [BYTE_W-1:0]     mem_wdata, mem_rdata;
  rd_tag_t               tag;
  logic                  push, pop;
  logic [OUT_W-1:0]      push_data;
  logic [OUT_W-1:0]      fifo_mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q, fifo_cnt_d;
  logic [FIFO_CNT_W-1:0] cred_q, cred_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= '0;
      map_height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        REG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hbs_issue u_issue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .can_query_i  (can_query),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .qry_acc_o    (qry_acc),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .tag_o        (tag)
  );

  hbs_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  hbs_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .rdata_i     (mem_rdata),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Credits cover every query from request to delivery, so the queue never overflows.
  always_comb begin
    pop          = rsp_o.valid && rsp_o.ready;
    can_query    = cred_q < FIFO_CNT_W'(FIFO_DEPTH);
    cred_d       = cred_q + FIFO_CNT_W'(qry_acc) - FIFO_CNT_W'(pop);
    fifo_cnt_d   = fifo_cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    rsp_o.valid  = fifo_cnt_q != '0;
    rsp_o.height_value = fifo_mem_q[rptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      fifo_cnt_q <= '0;
      cred_q     <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      fifo_cnt_q <= fifo_cnt_d;
      cred_q     <= cred_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem_q[wptr_q] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

  a_queue_within_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= cred_q)
    else $error("queued results exceed outstanding queries");

  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qry_acc |-> ##7 push)
    else $error("query result not pushed at fixed latency");

endmodule

// File: tb/hbs_tb_pkg.sv
// Request codes shared by the heightmap sampler testbench files.
// No dependencies; the checker and the testbench top import it.
package hbs_tb_pkg;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_e;

endpackage

// File: tb/hbs_height_checker.sv
// Watches the request, result and register ports of the heightmap sampler,
// keeps its own copy of the height grid and map size, and checks each height.
// Depends on hbs_pkg, hbs_tb_pkg, hbs_req_if and hbs_rsp_if.
module hbs_height_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hbs_pkg::CFG_W-1:0]     cfg_data_i,
  hbs_req_if                            req_mon,
  hbs_rsp_if                            rsp_mon,
  output int                            mismatch_cnt_o,
  output int                            pending_o,
  output int                            checked_o
);
  import hbs_pkg::*;
  import hbs_tb_pkg::*;

  bit   [BYTE_W-1:0] shadow_heights [STORE_DEPTH];
  logic [CFG_W-1:0]  map_w;
  logic [CFG_W-1:0]  map_h;
  logic [OUT_W-1:0]  height_due_q [$];

  function automatic longint fit_coord(input logic signed [COORD_W-1:0] q, input int dim);
    longint v;
    longint lim;
    v   = q;
    lim = longint'(dim - 1) << FRAC_BITS;
    if (v < 0) return 0;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [OUT_W-1:0] interp_height(input logic signed [COORD_W-1:0] qx,
                                                     input logic signed [COORD_W-1:0] qz);
    int     w, h, x0, x1, z0, z1;
    longint one, cx, cz, tx, tz, hx0, hx1, sum;
    w = (map_w > MAX_DIM) ? MAX_DIM : int'(map_w);
    h = (map_h > MAX_DIM) ? MAX_DIM : int'(map_h);
    if (w < 2 || h < 2) return '0;
    one = longint'(1) << FRAC_BITS;
    cx  = fit_coord(qx, w);
    cz  = fit_coord(qz, h);
    x0  = int'(cx >> FRAC_BITS);
    z0  = int'(cz >> FRAC_BITS);
    tx  = cx & (one - 1);
    tz  = cz & (one - 1);
    // far neighbor sticks to the last column/row
    x1  = (x0 + 1 < w) ? x0 + 1 : w - 1;
    z1  = (z0 + 1 < h) ? z0 + 1 : h - 1;
    hx0 = longint'(shadow_heights[z0 * MAX_DIM + x0]) * (one - tx)
        + longint'(shadow_heights[z0 * MAX_DIM + x1]) * tx;
    hx1 = longint'(shadow_heights[z1 * MAX_DIM + x0]) * (one - tx)
        + longint'(shadow_heights[z1 * MAX_DIM + x1]) * tx;
    sum = hx0 * (one - tz) + hx1 * tz;
    return (sum > longint'(OUT_MAX)) ? OUT_MAX : sum[OUT_W-1:0];
  endfunction

  always @(posedge clk_i) begin : watch
    logic [OUT_W-1:0] due;
    if (!rst_ni) begin
      map_w = '0;
      map_h = '0;
      height_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAP_WIDTH:  map_w = cfg_data_i;
          REG_MAP_HEIGHT: map_h = cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (height_due_q.size() == 0) begin
          mismatch_cnt_o++;
          $error("height_value: no query outstanding, expected none, got %0d",
                 rsp_mon.height_value);
        end else begin
          due = height_due_q.pop_front();
          checked_o++;
          if (rsp_mon.height_value !== due) begin
            mismatch_cnt_o++;
            $error("height_value: expected %0d (0x%06h), got %0d (0x%06h)",
                   due, due, rsp_mon.height_value, rsp_mon.height_value);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.req_type == REQ_LOAD)
          shadow_heights[int'(req_mon.load_row) * MAX_DIM + int'(req_mon.load_col)] =
            req_mon.load_value;
        else
          height_due_q = {height_due_q, interp_height(req_mon.query_x, req_mon.query_z)};
      end
    end
    pending_o = height_due_q.size();
  end

endmodule

// File: tb/tb_heightmap_bilinear_sampler_top.sv
// Testbench top for the heightmap bilinear sampler: clock, reset, map-size
// writes, height loads and lookups with random pacing, watchdog and verdict.
// Depends on hbs_pkg, hbs_tb_pkg, the channel interfaces and hbs_height_checker.
module tb_heightmap_bilinear_sampler_top;
  import hbs_pkg::*;
  import hbs_tb_pkg::*;

  localparam int ITEM_TARGET    = 1450;
  localparam int HOLD_CYCLES    = 240;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  hbs_req_if req_ch ();
  hbs_rsp_if rsp_ch ();

  int mismatch_cnt;
  int pending;
  int checked;

  bit cell_written [STORE_DEPTH];
  int map_w, map_h;
  bit pace_en  = 1'b1;
  bit rsp_hold = 1'b0;
  int n_items, n_loads, n_lookups, n_shapes;
  int quiet_cycles;

  always #1 clk = ~clk;

  heightmap_bilinear_sampler_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  hbs_height_checker u_height_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .req_mon        (req_ch),
    .rsp_mon        (rsp_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Cells a coordinate touches: clamped base cell and its edge-clamped neighbor.
  function automatic void cell_span(input logic signed [COORD_W-1:0] q, input int dim,
                                    output int lo, output int hi);
    int d, c, last;
    d = (dim > MAX_DIM) ? MAX_DIM : dim;
    if (d < 1) d = 1;
    last = (d - 1) << FRAC_BITS;
    c = q;
    if (c < 0) c = 0;
    if (c > last) c = last;
    lo = c >> FRAC_BITS;
    hi = (lo + 1 < d) ? lo + 1 : d - 1;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(input int dim);
    int last, r;
    last = ((dim > MAX_DIM) ? MAX_DIM : dim) - 1;
    if (last < 0) last = 0;
    r = $urandom_range(0, 99);
    if (r < 75) return COORD_W'($urandom_range(0, last << FRAC_BITS));
    // straddle an edge of the map
    if (r < 88)
      return COORD_W'(($urandom_range(0, 1) ? (last << FRAC_BITS) : 0)
                      + $urandom_range(0, 600) - 300);
    return COORD_W'($urandom);
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(2, 12);
    if (r < 80) return $urandom_range(13, MAX_DIM);
    if (r < 92) return $urandom_range(0, 1);
    return $urandom_range(MAX_DIM + 1, 1023);
  endfunction

  task automatic send_req(input req_kind_e kind, input logic [COL_W-1:0] col,
                          input logic [COL_W-1:0] row, input logic [BYTE_W-1:0] val,
                          input logic signed [COORD_W-1:0] qx,
                          input logic signed [COORD_W-1:0] qz);
    int gap;
    gap = pace_en ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.load_col   <= col;
    req_ch.load_row   <= row;
    req_ch.load_value <= val;
    req_ch.query_x    <= qx;
    req_ch.query_z    <= qz;
    do @(posedge clk); while (!req_ch.ready);
    n_items++;
    if (kind == REQ_LOAD) begin
      cell_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
      n_loads++;
    end else begin
      n_lookups++;
    end
  endtask

  task automatic load_cell(input int col, input int row, input logic [BYTE_W-1:0] val);
    send_req(REQ_LOAD, COL_W'(col), COL_W'(row), val, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic prime_cell(input int col, input int row);
    if (!cell_written[row * MAX_DIM + col]) load_cell(col, row, BYTE_W'($urandom));
  endtask

  // Load any neighbor the lookup reads that holds no height yet, then ask.
  task automatic ask_height(input logic signed [COORD_W-1:0] qx,
                            input logic signed [COORD_W-1:0] qz);
    int x0, x1, z0, z1;
    cell_span(qx, map_w, x0, x1);
    cell_span(qz, map_h, z0, z1);
    prime_cell(x0, z0);
    prime_cell(x1, z0);
    prime_cell(x0, z1);
    prime_cell(x1, z1);
    send_req(REQ_QUERY, COL_W'($urandom), COL_W'($urandom), BYTE_W'($urandom), qx, qz);
  endtask

  // Drop the request, wait for every outstanding height, let the pipe empty.
  task automatic quiesce();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_map(input int w, input int h);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_MAP_WIDTH;
    cfg_data <= CFG_W'(w);
    @(negedge clk);
    cfg_idx  <= REG_MAP_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(negedge clk);
    cfg_we   <= 1'b0;
    map_w = w;
    map_h = h;
    n_shapes++;
  endtask

  initial begin : rsp_sink
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (rsp_hold) begin
        stall    = HOLD_CYCLES;
        rsp_hold = 1'b0;
      end else begin
        stall = pace_en ? $urandom_range(0, 7) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_heightmap_bilinear_sampler_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int r, n, w, h, lim_w, lim_h, round;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_MAP_WIDTH;
    cfg_data          <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_LOAD;
    req_ch.load_col   <= '0;
    req_ch.load_row   <= '0;
    req_ch.load_value <= '0;
    req_ch.query_x    <= '0;
    req_ch.query_z    <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Small map with a checkerboard of extreme heights, corners and clamping.
    set_map(4, 3);
    for (int row = 0; row < 3; row++)
      for (int col = 0; col < 4; col++)
        load_cell(col, row, ((col + row) % 2 != 0) ? 8'hFF : 8'h00);
    ask_height(18'sh00000, 18'sh00000);
    ask_height(18'sh00300, 18'sh00200);
    ask_height(18'sh20000, 18'sh1FFFF);
    ask_height(18'sh00180, 18'sh000C0);
    ask_height(18'sh1FFFF, -18'sd1);
    ask_height(18'sh002FF, 18'sh001FF);
    load_cell(MAX_DIM - 1, MAX_DIM - 1, 8'hFF);
    load_cell(0, MAX_DIM - 1, 8'h5A);

    // Degenerate sizes give zero.
    quiesce();
    set_map(0, 5);
    ask_height(18'sh00100, 18'sh00100);
    quiesce();
    set_map(1, 1);
    ask_height(pick_coord(4), pick_coord(4));
    quiesce();
    set_map(7, 1);
    ask_height(18'sh00300, 18'sh00080);

    // Oversized registers clip to the store, then the smallest real map.
    quiesce();
    set_map(1023, 600);
    ask_height(18'sh1FFFF, 18'sh1FFFF);
    ask_height(-18'sd5, 18'sh1FF00);
    quiesce();
    set_map(2, 2);
    ask_height(18'sh00080, 18'sh00080);
    ask_height(18'sh3FFFF, 18'sh00100);

    round = 0;
    while (n_items < ITEM_TARGET) begin
      quiesce();
      if (round == 0 || round == 6) begin
        // Back up the result side while lookups keep coming.
        w        = 5;
        h        = 5;
        rsp_hold = 1'b1;
        pace_en  = 1'b0;
        n        = 40;
      end else begin
        w       = pick_dim();
        h       = pick_dim();
        pace_en = ($urandom_range(0, 3) != 0);
        n       = $urandom_range(40, 110);
      end
      set_map(w, h);
      lim_w = (w > MAX_DIM) ? MAX_DIM : ((w < 1) ? 1 : w);
      lim_h = (h > MAX_DIM) ? MAX_DIM : ((h < 1) ? 1 : h);
      for (int i = 0; i < n && n_items < ITEM_TARGET; i++) begin
        r = $urandom_range(0, 99);
        if (r < 12)
          load_cell($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                    BYTE_W'($urandom));
        else if (r < 28)
          load_cell($urandom_range(0, lim_w - 1), $urandom_range(0, lim_h - 1),
                    BYTE_W'($urandom));
        else
          ask_height(pick_coord(w), pick_coord(h));
      end
      round++;
    end
    quiesce();

    $display("Ran %0d requests (%0d height loads, %0d lookups) over %0d map sizes;",
             n_items, n_loads, n_lookups, n_shapes);
    $display("%0d interpolated heights compared, %0d mismatches.", checked, mismatch_cnt);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("tb_heightmap_bilinear_sampler_top: PASS");
    end else begin
      $display("tb_heightmap_bilinear_sampler_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hbs_pkg.sv
rtl/hbs_req_if.sv
rtl/hbs_rsp_if.sv
rtl/hbs_ram.sv
rtl/hbs_issue.sv
rtl/hbs_blend.sv
rtl/heightmap_bilinear_sampler_top.sv
tb/hbs_tb_pkg.sv
tb/hbs_height_checker.sv
tb/tb_heightmap_bilinear_sampler_top.sv
